[rtl/core/assert_macros.svh]
// Assertion macros shared by the stick conditioning RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high
`define SRDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset
`define SRDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRDS_ASSERT(lbl, clk, rst, prop, msg)
`define SRDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/srds_pkg.sv]
// Shared types and constants for the stick radial deadzone smoother.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package srds_pkg;

  // Bit-serial units all run one bit per cycle over 16 steps
  localparam int unsigned SERIAL_STEPS = 16;
  localparam int unsigned STEP_CNT_W   = 5;

  // Q1.15 unity
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Register reset values
  localparam logic [14:0] DEADZONE_RESET = 15'd3277;
  localparam logic [15:0] ALPHA_RESET    = 16'h8000;

  // Register indexes
  localparam logic CFG_DEADZONE = 1'b0;
  localparam logic CFG_ALPHA    = 1'b1;

  // Control to a serial unit: load operands, or advance one bit
  typedef struct packed {
    logic load;
    logic step;
  } serial_ctl_t;

endpackage

[rtl/core/stick_radial_deadzone_smoother.sv]
// Radial deadzone and exponential smoothing for analog sticks, Q1.15 data.
// One item in flight at a time: input is accepted only while idle. Work runs in six
// bit-serial phases (squares, root, rescale divide, scale, axis divide, blend), then a
// rounding step; inside the deadzone the sequence ends at the start of the root phase.
// Reset (synchronous, rst high) restores the register defaults, clears both
// smoothing histories and drops any pending result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stick_radial_deadzone_smoother import srds_pkg::*; #(
  parameter int STICK_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] raw_x, [31:16] raw_y
  input  logic        s_axis_tuser,   // [0] stick_select
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_x, [31:16] out_y
  // Register writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (STICK_COUNT > 1) ? $clog2(STICK_COUNT) : 1;
  localparam logic signed [33:0] RND_POS = 34'sd16384;
  localparam logic signed [33:0] RND_NEG = 34'sd16383;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(SERIAL_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE_DIV,
    ST_SCALE_MUL,
    ST_AXIS_DIV,
    ST_SMOOTH,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [STEP_CNT_W-1:0]   cnt;
  logic [14:0]             dz_reg;
  logic [15:0]             alpha_reg;
  logic [IDX_W-1:0]        idx_q;
  logic [15:0]             ax, ay;
  logic                    neg_x, neg_y;
  logic                    dz_hit, sat_s;
  logic signed [33:0]      acc_x, acc_y;
  logic signed [16:0]      prev_x [STICK_COUNT];
  logic signed [16:0]      prev_y [STICK_COUNT];
  logic [15:0]             out_x, out_y;
  logic                    out_valid;

  logic [15:0]        a_w, b_w;
  logic               phase_ld, phase_last, mul_phase, div_phase;
  serial_ctl_t        mul_ctl, sqrt_ctl, div_ctl;
  logic signed [17:0] mc0, mc1, mc2, mc3;
  logic [15:0]        mp0, mp1, mp2, mp3;
  logic signed [33:0] prod0, prod1, prod2, prod3;
  logic [31:0]        mag2, dz2;
  logic               in_dz;
  logic [15:0]        root;
  logic [15:0]        diff, den_s, s_val;
  logic [31:0]        scale_num, half_m;
  logic [31:0]        num0, num1;
  logic [15:0]        den0;
  logic [15:0]        quot_x, quot_y;
  logic signed [16:0] qx_s, qy_s, p_x, p_y;
  logic signed [16:0] prev_x_sel, prev_y_sel;
  logic signed [33:0] rnd_x, rnd_y;
  logic signed [16:0] sm_x, sm_y;
  logic [15:0]        sat_x, sat_y;

  // Blend weights, alpha limited to one
  assign a_w = (alpha_reg > ONE_Q15) ? ONE_Q15 : alpha_reg;
  assign b_w = ONE_Q15 - a_w;

  // Phase sequencing: step 0 loads the units, steps 1..16 run them
  assign phase_ld   = (cnt == '0);
  assign phase_last = (cnt == LAST_STEP);
  assign mul_phase  = (state == ST_SQUARE) || (state == ST_SCALE_MUL) || (state == ST_SMOOTH);
  assign div_phase  = (state == ST_SCALE_DIV) || (state == ST_AXIS_DIV);

  assign mul_ctl.load  = mul_phase && phase_ld;
  assign mul_ctl.step  = mul_phase && !phase_ld;
  assign sqrt_ctl.load = (state == ST_ROOT) && phase_ld;
  assign sqrt_ctl.step = (state == ST_ROOT) && !phase_ld;
  assign div_ctl.load  = div_phase && phase_ld;
  assign div_ctl.step  = div_phase && !phase_ld;

  // Deadzone test on the squared magnitude
  assign mag2  = prod0[31:0] + prod1[31:0];
  assign dz2   = prod2[31:0];
  assign in_dz = (mag2 < dz2);

  // Rescale from [deadzone, 1] to [0, 1]; saturates when m - dz reaches 1 - dz
  assign diff      = root - {1'b0, dz_reg};
  assign den_s     = ONE_Q15 - {1'b0, dz_reg};
  assign scale_num = {1'b0, diff, 15'b0} + 32'(den_s[15:1]);
  assign s_val     = sat_s ? ONE_Q15 : quot_x;
  assign half_m    = 32'(root[15:1]);

  // Scaled axes with sign restored, zero for a zero vector
  assign qx_s = signed'({1'b0, quot_x});
  assign qy_s = signed'({1'b0, quot_y});
  assign p_x  = (root == '0) ? '0 : (neg_x ? -qx_s : qx_s);
  assign p_y  = (root == '0) ? '0 : (neg_y ? -qy_s : qy_s);

  assign prev_x_sel = prev_x[idx_q];
  assign prev_y_sel = prev_y[idx_q];

  // Multiplier operands per phase
  always_comb begin
    mc0 = '0; mp0 = '0;
    mc1 = '0; mp1 = '0;
    mc2 = '0; mp2 = '0;
    mc3 = '0; mp3 = '0;
    case (state)
      ST_SQUARE: begin
        mc0 = signed'({2'b00, ax});   mp0 = ax;
        mc1 = signed'({2'b00, ay});   mp1 = ay;
        mc2 = signed'({3'b000, dz_reg}); mp2 = {1'b0, dz_reg};
      end
      ST_SCALE_MUL: begin
        mc0 = signed'({2'b00, ax});   mp0 = s_val;
        mc1 = signed'({2'b00, ay});   mp1 = s_val;
      end
      ST_SMOOTH: begin
        mc0 = 18'(p_x);        mp0 = a_w;
        mc1 = 18'(prev_x_sel); mp1 = b_w;
        mc2 = 18'(p_y);        mp2 = a_w;
        mc3 = 18'(prev_y_sel); mp3 = b_w;
      end
      default: ;
    endcase
  end

  // Divider operands per phase
  always_comb begin
    if (state == ST_AXIS_DIV) begin
      num0 = prod0[31:0] + half_m;
      num1 = prod1[31:0] + half_m;
      den0 = root;
    end else begin
      num0 = scale_num;
      num1 = scale_num;
      den0 = den_s;
    end
  end

  srds_smul u_mul0 (.clk(clk), .ctl(mul_ctl), .mcand(mc0), .mplier(mp0), .prod(prod0));
  srds_smul u_mul1 (.clk(clk), .ctl(mul_ctl), .mcand(mc1), .mplier(mp1), .prod(prod1));
  srds_smul u_mul2 (.clk(clk), .ctl(mul_ctl), .mcand(mc2), .mplier(mp2), .prod(prod2));
  srds_smul u_mul3 (.clk(clk), .ctl(mul_ctl), .mcand(mc3), .mplier(mp3), .prod(prod3));

  srds_sqrt u_sqrt (.clk(clk), .ctl(sqrt_ctl), .radicand(mag2), .root(root));

  srds_div u_div_x (.clk(clk), .ctl(div_ctl), .num(num0), .den(den0), .quot(quot_x));
  srds_div u_div_y (.clk(clk), .ctl(div_ctl), .num(num1), .den(den0), .quot(quot_y));

  // Round half away from zero by 2^15, then saturate to 16 bits
  assign rnd_x = acc_x + (acc_x[33] ? RND_NEG : RND_POS);
  assign rnd_y = acc_y + (acc_y[33] ? RND_NEG : RND_POS);
  assign sm_x  = rnd_x[31:15];
  assign sm_y  = rnd_y[31:15];
  assign sat_x = (!sm_x[16] && sm_x[15]) ? 16'h7FFF : sm_x[15:0];
  assign sat_y = (!sm_y[16] && sm_y[15]) ? 16'h7FFF : sm_y[15:0];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_reg    <= DEADZONE_RESET;
      alpha_reg <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE: dz_reg    <= cfg_data[14:0];
        CFG_ALPHA:    alpha_reg <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Sequencer, history and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      dz_hit    <= 1'b0;
      sat_s     <= 1'b0;
      for (int i = 0; i < STICK_COUNT; i++) begin
        prev_x[i] <= '0;
        prev_y[i] <= '0;
      end
    end else begin
      if (out_valid && m_axis_tready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx_q  <= (STICK_COUNT > 1) ? IDX_W'(s_axis_tuser) : '0;
            neg_x  <= s_axis_tdata[15];
            neg_y  <= s_axis_tdata[31];
            ax     <= s_axis_tdata[15] ? 16'(~s_axis_tdata[15:0] + 16'd1)
                                       : s_axis_tdata[15:0];
            ay     <= s_axis_tdata[31] ? 16'(~s_axis_tdata[31:16] + 16'd1)
                                       : s_axis_tdata[31:16];
            dz_hit <= 1'b0;
            cnt    <= '0;
            state  <= ST_SQUARE;
          end
        end
        ST_ROOT: begin
          if (phase_ld && in_dz) begin
            dz_hit <= 1'b1;
            state  <= ST_DONE;
          end else if (phase_last) begin
            cnt   <= '0;
            state <= ST_SCALE_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SQUARE, ST_SCALE_DIV, ST_SCALE_MUL, ST_AXIS_DIV, ST_SMOOTH: begin
          if (state == ST_SCALE_DIV && phase_ld) begin
            sat_s <= (diff >= den_s);
          end
          if (phase_last) begin
            cnt <= '0;
            unique case (state)
              ST_SQUARE:    state <= ST_ROOT;
              ST_SCALE_DIV: state <= ST_SCALE_MUL;
              ST_SCALE_MUL: state <= ST_AXIS_DIV;
              ST_AXIS_DIV:  state <= ST_SMOOTH;
              default:      state <= ST_ROUND;
            endcase
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROUND: begin
          acc_x <= prod0 + prod1;
          acc_y <= prod2 + prod3;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid     <= 1'b1;
            out_x         <= dz_hit ? '0 : sat_x;
            out_y         <= dz_hit ? '0 : sat_y;
            prev_x[idx_q] <= dz_hit ? '0 : sm_x;
            prev_y[idx_q] <= dz_hit ? '0 : sm_y;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x};

  // Checks
  `SRDS_ASSERT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in flight")
  `SRDS_ASSERT(a_result_from_done, clk, rst, $rose(m_axis_tvalid) |-> $past(state == ST_DONE), "result raised outside the final step")
  `SRDS_ASSERT(a_scaled_range, clk, rst, state == ST_SMOOTH |-> p_x <= 17'sd32768 && p_x >= -17'sd32768 && p_y <= 17'sd32768 && p_y >= -17'sd32768, "scaled axis out of range")
  `SRDS_ASSERT_ALWAYS(a_reset_clean, clk, $past(rst) && !rst |-> !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

[rtl/core/srds_smul.sv]
// Bit-serial multiplier: signed multiplicand times unsigned 16-bit multiplier.
// Depends on srds_pkg for the control struct.
`timescale 1ns / 1ps
module srds_smul import srds_pkg::*; (
  input  logic               clk,
  input  serial_ctl_t        ctl,
  input  logic signed [17:0] mcand,
  input  logic [15:0]        mplier,
  output logic signed [33:0] prod
);

  logic signed [33:0] mc_sh;
  logic [15:0]        mp_sh;

  // Shift-and-add, lowest multiplier bit first
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod  <= '0;
      mc_sh <= 34'(mcand);
      mp_sh <= mplier;
    end else if (ctl.step) begin
      if (mp_sh[0]) begin
        prod <= prod + mc_sh;
      end
      mc_sh <= mc_sh <<< 1;
      mp_sh <= mp_sh >> 1;
    end
  end

endmodule

[rtl/core/srds_sqrt.sv]
// Bit-serial integer square root of a 32-bit value, one root bit per step.
// Depends on srds_pkg for the control struct.
`timescale 1ns / 1ps
module srds_sqrt import srds_pkg::*; (
  input  logic        clk,
  input  serial_ctl_t ctl,
  input  logic [31:0] radicand,
  output logic [15:0] root
);

  logic [31:0] rad_sh;
  logic [16:0] rem;
  logic [18:0] rem_sh;
  logic [18:0] trial;

  // Bring down the next pair of bits, trial subtract 4*root+1
  assign rem_sh = {rem, rad_sh[31:30]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (ctl.step) begin
      rad_sh <= rad_sh << 2;
      if (rem_sh >= trial) begin
        rem  <= 17'(rem_sh - trial);
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rem_sh[16:0];
        root <= {root[14:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/srds_div.sv]
// Bit-serial restoring divider: 32-bit dividend, 16-bit divisor, 16-bit quotient.
// Caller guarantees the dividend is below divisor * 65536. Depends on srds_pkg.
`timescale 1ns / 1ps
module srds_div import srds_pkg::*; (
  input  logic        clk,
  input  serial_ctl_t ctl,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic [15:0] quot
);

  logic [15:0] rem;
  logic [15:0] num_lo;
  logic [15:0] den_q;
  logic [16:0] trial;

  assign trial = {rem, num_lo[15]};

  // One quotient bit per step, remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem    <= num[31:16];
      num_lo <= num[15:0];
      den_q  <= den;
      quot   <= '0;
    end else if (ctl.step) begin
      num_lo <= num_lo << 1;
      if (trial >= {1'b0, den_q}) begin
        rem  <= 16'(trial - {1'b0, den_q});
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= trial[15:0];
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

endmodule
